>>> design/averaged_deadband_reporter_defines.svh
// Assertion macros used by the averaged deadband reporter top level.
`ifndef AVERAGED_DEADBAND_REPORTER_DEFINES_SVH
`define AVERAGED_DEADBAND_REPORTER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that cond holds in the same cycle as trig.
`define ADR_ASSERT_IMPLY(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed: same-cycle implication");

// Checks that cond holds in the cycle after trig.
`define ADR_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ADR_ASSERT_IMPLY(label, clk, rst, trig, cond)
`define ADR_ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

>>> design/adr_pkg.sv
// Types and constants shared by the averaged deadband reporter modules.
`default_nettype none

package adr_pkg;

   // Field widths.
   localparam int SAMPLE_W   = 24;
   localparam int WEIGHT_W   = 23;
   localparam int THRESH_W   = 23;
   localparam int INTERVAL_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // The register index is the word address bit of paddr.
   localparam int REG_INDEX_BIT = 2;

   localparam logic [WEIGHT_W-1:0]   WEIGHT_MAX  = {WEIGHT_W{1'b1}};
   localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = {INTERVAL_W{1'b1}};

   // Register reset values.
   localparam logic [THRESH_W-1:0]   THRESH_RESET   = 23'd50;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd3600000;

   // Register indexes.
   localparam logic REG_CHANGE_THRESHOLD = 1'b0;
   localparam logic REG_INTERVAL_MS      = 1'b1;

   // Request kinds.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Queue word kinds.
   localparam logic KIND_BLOCK = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // One word passed from the front to the back.
   typedef struct packed {
      logic                kind;
      logic [WEIGHT_W-1:0] weight;
      logic                link;
   } adr_entry_type;

   // Current register settings.
   typedef struct packed {
      logic [THRESH_W-1:0]   change_threshold;
      logic [INTERVAL_W-1:0] interval_ms;
   } adr_cfg_type;

endpackage

`default_nettype wire

>>> design/adr_csr.sv
// Register block of the averaged deadband reporter on an APB-style port.
`default_nettype none

module adr_csr
   import adr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output adr_cfg_type                cfg
);

   logic [THRESH_W-1:0]   thresh_ff;
   logic [THRESH_W-1:0]   thresh_in;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [INTERVAL_W-1:0] interval_in;
   logic                  write_en;
   logic                  reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[REG_INDEX_BIT];

   // Register writes in the access cycle.
   always_comb begin
      thresh_in   = thresh_ff;
      interval_in = interval_ff;
      if (write_en) begin
         case (reg_index)
            REG_CHANGE_THRESHOLD: thresh_in   = csr_pwdata[THRESH_W-1:0];
            REG_INTERVAL_MS:      interval_in = csr_pwdata[INTERVAL_W-1:0];
            default:              thresh_in   = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= THRESH_RESET;
         interval_ff <= INTERVAL_RESET;
      end else begin
         thresh_ff   <= thresh_in;
         interval_ff <= interval_in;
      end
   end

   // Read data.
   always_comb begin
      case (reg_index)
         REG_CHANGE_THRESHOLD: csr_prdata = CSR_DATA_W'(thresh_ff);
         REG_INTERVAL_MS:      csr_prdata = CSR_DATA_W'(interval_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg.change_threshold = thresh_ff;
   assign cfg.interval_ms      = interval_ff;

endmodule

`default_nettype wire

>>> design/adr_front.sv
// Front end: accepts words, sums samples and forms the rounded block average.
`default_nettype none

module adr_front
   import adr_pkg::*;
#(
   parameter int AVG_COUNT = 5
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_kind,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire logic                req_link,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output adr_entry_type            push_entry
);

   localparam int CNT_W = $clog2(AVG_COUNT + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;
   localparam int SHIFT = SUM_W + $clog2(AVG_COUNT);
   localparam int MUL_W = SUM_W + 2;
   localparam int PROD_W = SHIFT + SUM_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
   localparam logic [MUL_W-1:0] RECIP      = RECIP_FULL[MUL_W-1:0];
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(AVG_COUNT - 1);
   localparam logic [SUM_W-1:0] HALF       = SUM_W'(AVG_COUNT / 2);
   localparam logic [SUM_W-1:0] WEIGHT_LIM = SUM_W'(WEIGHT_MAX);

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;

   logic                    a_valid_ff;
   logic                    a_valid_in;
   logic                    a_tick_ff;
   logic                    a_pos_ff;
   logic                    a_link_ff;
   logic [SUM_W-1:0]        a_x_ff;

   logic                    b_valid_ff;
   logic                    b_valid_in;
   logic                    b_tick_ff;
   logic                    b_pos_ff;
   logic                    b_link_ff;
   logic [PROD_W-1:0]       b_prod_ff;

   logic                    accept;
   logic                    is_sample;
   logic                    block_done;
   logic                    a_load;
   logic                    a_free;
   logic                    a_move;
   logic                    b_free;
   logic                    b_move;
   logic signed [SUM_W-1:0] sample_ext;
   logic signed [SUM_W-1:0] sum_next;
   logic                    sum_pos;
   logic [SUM_W-1:0]        x_next;
   logic [SUM_W-1:0]        quot;
   logic [WEIGHT_W-1:0]     avg;

   // Stage handshakes: each stage moves on when the one after it has room.
   assign b_move    = b_valid_ff && push_ready;
   assign b_free    = !b_valid_ff || push_ready;
   assign a_move    = a_valid_ff && b_free;
   assign a_free    = !a_valid_ff || b_free;
   assign req_ready = a_free;
   assign accept    = req_valid && req_ready;

   // Running sum of the current block.
   assign is_sample  = (req_kind == REQ_SAMPLE);
   assign block_done = is_sample && (count_ff == LAST_COUNT);
   assign sample_ext = SUM_W'($signed(req_sample));
   assign sum_next   = sum_ff + sample_ext;
   assign sum_pos    = !sum_next[SUM_W-1] && (|sum_next);
   assign x_next     = $unsigned(sum_next) + HALF;
   assign a_load     = accept && (!is_sample || block_done);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept && is_sample) begin
         if (block_done) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      if (a_load) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
      if (a_move) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Stage A holds the rounded sum; stage B holds its product by the reciprocal.
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_tick_ff <= !is_sample;
         a_pos_ff  <= sum_pos;
         a_link_ff <= req_link;
         a_x_ff    <= x_next;
      end
      if (a_move) begin
         b_tick_ff <= a_tick_ff;
         b_pos_ff  <= a_pos_ff;
         b_link_ff <= a_link_ff;
         b_prod_ff <= PROD_W'(a_x_ff) * PROD_W'(RECIP);
      end
   end

   // The quotient is exact for every sum the block can reach.
   assign quot = b_prod_ff[SHIFT +: SUM_W];

   always_comb begin
      if (!b_pos_ff) begin
         avg = '0;
      end else if (quot > WEIGHT_LIM) begin
         avg = WEIGHT_MAX;
      end else begin
         avg = quot[WEIGHT_W-1:0];
      end
   end

   assign push_valid        = b_valid_ff;
   assign push_entry.kind   = b_tick_ff ? KIND_TICK : KIND_BLOCK;
   assign push_entry.weight = avg;
   assign push_entry.link   = b_link_ff;

endmodule

`default_nettype wire

>>> design/adr_queue.sv
// Short first-in first-out queue of words between the front and the back.
`default_nettype none

module adr_queue
   import adr_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire adr_entry_type push_entry,
   output logic               pop_valid,
   input  wire logic          pop,
   output adr_entry_type      pop_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   adr_entry_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> design/adr_back.sv
// Back end: keeps elapsed time and last sent value, decides and registers reports.
`default_nettype none

module adr_back
   import adr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire adr_cfg_type   cfg,
   input  wire logic          q_valid,
   input  wire adr_entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [WEIGHT_W-1:0] rsp_weight,
   output logic               rsp_sent
);

   logic [WEIGHT_W-1:0]   last_ff;
   logic [WEIGHT_W-1:0]   last_in;
   logic [INTERVAL_W-1:0] elapsed_ff;
   logic [INTERVAL_W-1:0] elapsed_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [WEIGHT_W-1:0]   weight_ff;
   logic                  sent_ff;

   logic                  is_block;
   logic [WEIGHT_W-1:0]   diff;
   logic                  trigger;
   logic                  report;
   logic                  send;

   // A word is taken whenever the output register is free or being emptied.
   assign q_pop    = q_valid && (!valid_ff || rsp_ready);
   assign is_block = (q_entry.kind == KIND_BLOCK);

   // Distance from the last sent value, and the report decision.
   assign diff    = (q_entry.weight >= last_ff) ? q_entry.weight - last_ff
                                                : last_ff - q_entry.weight;
   assign trigger = (diff >= cfg.change_threshold) || (elapsed_ff >= cfg.interval_ms);
   assign report  = q_pop && is_block && trigger;
   assign send    = report && q_entry.link;

   always_comb begin
      last_in    = last_ff;
      elapsed_in = elapsed_ff;
      if (send) begin
         last_in    = q_entry.weight;
         elapsed_in = '0;
      end else if (q_pop && !is_block && (elapsed_ff != ELAPSED_MAX)) begin
         elapsed_in = elapsed_ff + INTERVAL_W'(1);
      end
      if (report) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         elapsed_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         last_ff    <= last_in;
         elapsed_ff <= elapsed_in;
         valid_ff   <= valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (report) begin
         weight_ff <= q_entry.weight;
         sent_ff   <= q_entry.link;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_weight = weight_ff;
   assign rsp_sent   = sent_ff;

endmodule

`default_nettype wire

>>> design/averaged_deadband_reporter.sv
// Top level of the averaged deadband reporter.
//
// The block takes one request word per clock cycle, either a weight sample or
// a one-millisecond tick, and keeps taking words while a result waits on the
// response side until its internal queue of QUEUE_DEPTH words and the two
// averaging stages in front of it are full. Every AVG_COUNT samples it forms
// the rounded average (negative averages read as zero) and reports it when it
// moved by at least change_threshold from the last sent value or when
// interval_ms milliseconds have passed since the last send; tuser on the
// response says whether the report went out (link ready) or was skipped.
// rsp_tvalid rises after the sample closing its block has passed the
// rounded-sum register, the reciprocal multiply register, the queue and the
// output register. The sustained rate of one word per cycle, while the
// response side keeps up, is set by the single-register accumulator in the
// front and the registered update of elapsed time and last sent value in
// the back. Write the registers only while no words are in flight.
`default_nettype none
`include "averaged_deadband_reporter_defines.svh"

module averaged_deadband_reporter
   import adr_pkg::*;
#(
   parameter int AVG_COUNT   = 5,
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [23:0] sample_tenths, [24] link_ready, [31:25] zero
   input  wire logic [31:0]           req_tdata,
   // [0] req_type
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [22:0] weight_tenths, [23] zero
   output logic      [23:0]           rsp_tdata,
   // [0] sent
   output logic      [0:0]            rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   adr_cfg_type         cfg;
   logic                push_valid;
   logic                push_ready;
   adr_entry_type       push_entry;
   logic                q_valid;
   logic                q_pop;
   adr_entry_type       q_entry;
   logic [WEIGHT_W-1:0] rsp_weight;
   logic                rsp_sent;
   logic                front_stall;
   logic                pop_block;

   // Registers.
   adr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Accumulate and average.
   adr_front #(
      .AVG_COUNT (AVG_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser[0]),
      .req_sample (req_tdata[SAMPLE_W-1:0]),
      .req_link   (req_tdata[SAMPLE_W]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Queue between front and back.
   adr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_entry)
   );

   // Report decision and output register.
   adr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_weight (rsp_weight),
      .rsp_sent   (rsp_sent)
   );

   assign rsp_tdata = {1'b0, rsp_weight};
   assign rsp_tuser = rsp_sent;

   // Terms used by the checks below.
   assign front_stall = push_valid && !push_ready;
   assign pop_block   = q_pop && (q_entry.kind == KIND_BLOCK);

   // The front keeps its word steady while the queue is full.
   `ADR_ASSERT_NEXT(a_front_holds, clock, reset, front_stall, push_valid && $stable(push_entry))
   // A new result only comes from a block word taken from the queue.
   `ADR_ASSERT_IMPLY(a_result_from_block, clock, reset, $rose(rsp_tvalid), $past(pop_block))
   // Nothing leaves the queue while a result is stalled.
   `ADR_ASSERT_IMPLY(a_no_pop_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !q_pop)

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the averaged deadband reporter: table-driven and random traffic.
module tb_top;
   import adr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES_PER_AVG = 5;
   localparam int DRAIN_CYCLES    = 12;
   localparam int STALL_LIMIT     = 2000;
   localparam int PHASE_WORDS     = 82;
   localparam int PHASE_COUNT     = 6;

   // One expected report on the response side.
   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                sent;
   } weight_report_type;

   // One row of the directed table; typed rows carry the report they must cause.
   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
      logic                link;
      logic                typed;
      logic [WEIGHT_W-1:0] weight;
      logic                sent;
   } scale_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam scale_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // Five samples of 10.0 g with the link up: the move from zero is reported and sent.
      '{REQ_SAMPLE, 24'd100,     1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd100,     1'b0, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd100,     1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd100,     1'b0, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd100,     1'b1, 1'b1, 23'd100,      1'b1},
      // Largest samples with the link down: the full-scale average is skipped.
      '{REQ_SAMPLE, 24'h7FFFFF,  1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h7FFFFF,  1'b0, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h7FFFFF,  1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h7FFFFF,  1'b0, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h7FFFFF,  1'b0, 1'b1, 23'h7FFFFF,   1'b0},
      // Most negative samples: the average clamps to zero and is sent.
      '{REQ_SAMPLE, 24'h800000,  1'b0, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h800000,  1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h800000,  1'b0, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h800000,  1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'h800000,  1'b1, 1'b1, 23'd0,        1'b1},
      // Zero samples with ticks mixed in: no change and no heartbeat, so no report.
      '{REQ_SAMPLE, 24'd0,       1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_TICK,   24'hFFFFFF,  1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd0,       1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_TICK,   24'd0,       1'b0, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd0,       1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd0,       1'b1, 1'b0, 23'd0,        1'b0},
      '{REQ_SAMPLE, 24'd0,       1'b1, 1'b0, 23'd0,        1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;  // [23:0] sample_tenths, [24] link_ready, [31:25] zero
   logic [0:0]            req_tuser = '0;  // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;       // [22:0] weight_tenths, [23] zero
   logic [0:0]            rsp_tuser;       // [0] sent
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Scale model state and settings.
   longint                block_sum = 0;
   int unsigned           block_count = 0;
   logic [WEIGHT_W-1:0]   last_sent = '0;
   logic [INTERVAL_W-1:0] elapsed = '0;
   logic [THRESH_W-1:0]   threshold = THRESH_RESET;
   logic [INTERVAL_W-1:0] heartbeat = INTERVAL_RESET;

   weight_report_type pending_reports[$];
   weight_report_type oldest_report;
   int unsigned       mismatch_count = 0;
   int unsigned       words_sent = 0;
   int unsigned       stall_cycles = 0;
   bit                send_steady = 1'b0;
   bit                take_steady = 1'b0;

   averaged_deadband_reporter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Advances the scale state by one word; returns 1 when the word causes a report.
   function automatic bit predict_report(input logic kind,
                                         input logic signed [SAMPLE_W-1:0] sample,
                                         input logic link, output weight_report_type rep);
      longint              avg;
      logic [WEIGHT_W-1:0] avg_w;
      logic [WEIGHT_W-1:0] change;
      rep = '0;
      if (kind == REQ_TICK) begin
         if (elapsed != ELAPSED_MAX) elapsed++;
         return 1'b0;
      end
      block_sum += longint'(sample);
      block_count++;
      if (block_count < SAMPLES_PER_AVG) return 1'b0;
      // Round to nearest with ties up; a sum of zero or less reads as zero.
      avg = (block_sum <= 0) ? 0 : (block_sum + SAMPLES_PER_AVG / 2) / SAMPLES_PER_AVG;
      if (avg > longint'(WEIGHT_MAX)) avg = longint'(WEIGHT_MAX);
      avg_w = avg[WEIGHT_W-1:0];
      block_sum = 0;
      block_count = 0;
      change = (avg_w >= last_sent) ? avg_w - last_sent : last_sent - avg_w;
      if (!(change >= threshold || elapsed >= heartbeat)) return 1'b0;
      // A skipped report leaves the last value and the elapsed time alone.
      if (link) begin
         last_sent = avg_w;
         elapsed = '0;
      end
      rep.weight = avg_w;
      rep.sent = link;
      return 1'b1;
   endfunction

   // Sends one word after a random gap; called and returns at a falling edge.
   task automatic send_word(input logic kind, input logic [SAMPLE_W-1:0] sample, input logic link,
                            input logic typed, input weight_report_type typed_rep);
      int unsigned       gap;
      weight_report_type rep;
      bit                has_report;
      if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {7'd0, link, sample};
      req_tuser <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      has_report = predict_report(kind, sample, link, rep);
      if (typed) pending_reports.push_back(typed_rep);
      else if (has_report) pending_reports.push_back(rep);
      words_sent++;
      @(negedge clock);
   endtask

   // Register write: setup cycle and access cycle, then the bus returns to idle.
   task automatic write_register(input logic index, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(index) << REG_INDEX_BIT;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_CHANGE_THRESHOLD) threshold = value[THRESH_W-1:0];
      else heartbeat = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Holds the sender until every expected report is back and trailing ticks have settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // A full averaging block with random ticks in between.
   task automatic send_random_block(input int unsigned tick_max);
      logic [SAMPLE_W-1:0] samples [SAMPLES_PER_AVG];
      int unsigned         mode;
      int unsigned         base;
      longint              delta;
      longint              target;
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
         // Aim at the edge of the change threshold around the last sent value.
         case ($urandom_range(0, 3))
            0: delta = longint'(threshold);
            1: delta = (threshold != 0) ? longint'(threshold) - 1 : 0;
            2: delta = longint'(threshold) + 1;
            default: delta = longint'($urandom_range(0, threshold));
         endcase
         target = $urandom_range(0, 1) ? longint'(last_sent) + delta : longint'(last_sent) - delta;
         if (target < 0) target = 0;
         if (target > longint'(WEIGHT_MAX)) target = longint'(WEIGHT_MAX);
         foreach (samples[i]) samples[i] = target[SAMPLE_W-1:0];
      end else if (mode <= 6) begin
         foreach (samples[i]) samples[i] = SAMPLE_W'($urandom());
      end else if (mode == 7) begin
         foreach (samples[i]) begin
            case ($urandom_range(0, 3))
               0: samples[i] = 24'h7FFFFF;
               1: samples[i] = 24'h800000;
               2: samples[i] = 24'hFFFFFF;
               default: samples[i] = 24'h000000;
            endcase
         end
      end else begin
         // Small values with jitter so the rounding sees every remainder.
         base = $urandom_range(0, 1000);
         foreach (samples[i]) samples[i] = SAMPLE_W'(base + $urandom_range(0, 6)) - 24'd3;
      end
      foreach (samples[i]) begin
         repeat ($urandom_range(0, tick_max))
            send_word(REQ_TICK, SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)), 1'b0, '0);
         send_word(REQ_SAMPLE, samples[i], $urandom_range(0, 9) < 7, 1'b0, '0);
      end
   endtask

   // Response side: random readiness per word, with stretches of steady acceptance.
   initial begin
      int unsigned gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) take_steady = !take_steady;
         gap = take_steady ? 0 : $urandom_range(0, 17);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compare each accepted word with the oldest expected report.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected word: weight %0d sent %0b",
                                      rsp_tdata[WEIGHT_W-1:0], rsp_tuser[0]));
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_tdata[WEIGHT_W-1:0] != oldest_report.weight)
               report_mismatch($sformatf("weight %0d, expected %0d",
                                         rsp_tdata[WEIGHT_W-1:0], oldest_report.weight));
            if (rsp_tuser[0] != oldest_report.sent)
               report_mismatch($sformatf("sent flag %0b, expected %0b",
                                         rsp_tuser[0], oldest_report.sent));
         end
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Main sequence.
   initial begin
      weight_report_type typed_rep;
      logic [31:0]       thresh_word;
      logic [31:0]       interval_word;
      int unsigned       tick_max;
      int unsigned       quota;
      bit                paused;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows run on the settings left by reset.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         typed_rep.weight = DIRECTED_TABLE[r].weight;
         typed_rep.sent = DIRECTED_TABLE[r].sent;
         send_word(DIRECTED_TABLE[r].kind, DIRECTED_TABLE[r].sample, DIRECTED_TABLE[r].link,
                   DIRECTED_TABLE[r].typed, typed_rep);
      end
      wait_drained();

      // Random phases, each under its own register settings.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               thresh_word = 32'd0;
               interval_word = 32'd0;
               tick_max = 1;
            end
            1: begin
               thresh_word = 32'hFFFF_FFFF;
               interval_word = 32'hFFFF_FFFF;
               tick_max = 2;
            end
            2: begin
               thresh_word = $urandom_range(0, 200);
               interval_word = $urandom_range(1, 30);
               tick_max = 6;
            end
            3: begin
               // Reset-like settings with junk above the threshold field.
               thresh_word = $urandom();
               thresh_word[THRESH_W-1:0] = THRESH_RESET;
               interval_word = INTERVAL_RESET;
               tick_max = 2;
            end
            4: begin
               thresh_word = $urandom();
               interval_word = $urandom_range(0, 100);
               tick_max = 8;
            end
            default: begin
               thresh_word = $urandom_range(0, 20);
               interval_word = $urandom_range(5, 60);
               tick_max = 4;
            end
         endcase
         write_register(REG_CHANGE_THRESHOLD, thresh_word);
         write_register(REG_INTERVAL_MS, interval_word);
         quota = words_sent + PHASE_WORDS;
         paused = 1'b0;
         while (words_sent < quota) begin
            if ($urandom_range(0, 11) == 0) begin
               // Noise: a burst of ticks or a stray sample that shifts the block boundary.
               if ($urandom_range(0, 1))
                  repeat ($urandom_range(1, 8))
                     send_word(REQ_TICK, SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)),
                               1'b0, '0);
               else
                  send_word(REQ_SAMPLE, SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)),
                            1'b0, '0);
            end else begin
               send_random_block(tick_max);
            end
            if (phase == 2 && !paused && words_sent + PHASE_WORDS / 2 >= quota) begin
               wait_drained();
               paused = 1'b1;
            end
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
